FILE: hdl/tilt_orientation_debouncer_macros.svh
// Assertion macros for the tilt orientation debouncer.
// Included by the top level; depends on nothing.
`ifndef TILT_ORIENTATION_DEBOUNCER_MACROS_SVH
`define TILT_ORIENTATION_DEBOUNCER_MACROS_SVH

// same-cycle implication, off during reset
`define TOD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tod assertion failed");

// next-cycle implication, off during reset
`define TOD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tod assertion failed");

`endif

FILE: hdl/tod_pkg.sv
// Shared types and constants of the tilt orientation debouncer.
// No dependencies.
package tod_pkg;

    localparam int unsigned TOD_QUEUE_DEPTH = 2;
    localparam int unsigned TOD_IN_DATA_W   = 80;
    localparam int unsigned TOD_OUT_DATA_W  = 8;
    localparam int unsigned TOD_CFG_IDX_W   = 3;
    localparam int unsigned TOD_CFG_DATA_W  = 32;

    localparam logic [15:0] TOD_RST_DEBOUNCE   = 16'd250;
    localparam logic [31:0] TOD_RST_MIN_TOTAL  = 32'd4194304;
    localparam logic [31:0] TOD_RST_MAX_TOTAL  = 32'd48486154;
    localparam logic [31:0] TOD_RST_MIN_PLANAR = 32'd2055209;
    localparam logic [14:0] TOD_RST_MARGIN     = 15'd492;

    typedef enum logic [2:0] {
        REG_DEBOUNCE    = 3'd0,
        REG_MIN_TOTAL   = 3'd1,
        REG_MAX_TOTAL   = 3'd2,
        REG_MIN_PLANAR  = 3'd3,
        REG_AXIS_MARGIN = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        ORIENT_0   = 2'd0,
        ORIENT_90  = 2'd1,
        ORIENT_180 = 2'd2,
        ORIENT_270 = 2'd3
    } t_orient;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [31:0] min_total_sq;
        logic [31:0] max_total_sq;
        logic [31:0] min_planar_sq;
        logic [14:0] axis_margin;
    } t_cfg;

    // classified sample: has_prop low means keep committed
    typedef struct packed {
        logic        has_prop;
        t_orient     prop;
        logic [31:0] now_ms;
    } t_cls;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_sts;

    typedef struct packed {
        logic    pop;
        logic    commit;
        t_orient committed;
    } t_back_sts;

endpackage

FILE: hdl/tod_front.sv
// Front end: squares the sample, checks magnitude windows and axis lead.
// Depends on tod_pkg.
module tod_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [tod_pkg::TOD_IN_DATA_W-1:0]   i_data,
    input  logic                                i_sample_valid,
    input  tod_pkg::t_cfg                       i_cfg,
    input  logic                                i_full,
    output logic                                o_push,
    output tod_pkg::t_cls                       o_cls
);
    import tod_pkg::*;

    logic signed [15:0] x, y, z;
    logic signed [31:0] sq_x, sq_y, sq_z;
    logic        [15:0] abs_x, abs_y;

    logic               r_vld;
    logic        [30:0] r_xx, r_yy, r_zz;
    logic        [15:0] r_ax, r_ay;
    logic               r_xneg, r_yneg, r_ok;
    logic        [31:0] r_now;

    logic        [31:0] planar;
    logic        [32:0] total;
    logic        [16:0] ay_m, ax_m;
    logic               x_dom, y_dom, mag_ok;
    logic               advance;

    assign x = i_data[15:0];
    assign y = i_data[31:16];
    assign z = i_data[47:32];

    assign sq_x  = x * x;
    assign sq_y  = y * y;
    assign sq_z  = z * z;
    assign abs_x = x[15] ? 16'(-x) : 16'(x);
    assign abs_y = y[15] ? 16'(-y) : 16'(y);

    assign o_push  = r_vld && !i_full;
    assign advance = !r_vld || o_push;
    assign o_ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (advance) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_xx   <= sq_x[30:0];
            r_yy   <= sq_y[30:0];
            r_zz   <= sq_z[30:0];
            r_ax   <= abs_x;
            r_ay   <= abs_y;
            r_xneg <= x[15];
            r_yneg <= y[15];
            r_ok   <= i_sample_valid;
            r_now  <= i_data[79:48];
        end
    end

    assign planar = 32'(r_xx) + 32'(r_yy);
    assign total  = 33'(planar) + 33'(r_zz);
    assign mag_ok = (total >= 33'(i_cfg.min_total_sq)) &&
                    (total <= 33'(i_cfg.max_total_sq)) &&
                    (planar >= i_cfg.min_planar_sq);
    assign ay_m   = 17'(r_ay) + 17'(i_cfg.axis_margin);
    assign ax_m   = 17'(r_ax) + 17'(i_cfg.axis_margin);
    assign x_dom  = 17'(r_ax) > ay_m;
    assign y_dom  = 17'(r_ay) > ax_m;

    always_comb begin
        o_cls.now_ms   = r_now;
        o_cls.has_prop = r_ok && mag_ok && (x_dom || y_dom);
        if (x_dom) begin
            o_cls.prop = r_xneg ? ORIENT_270 : ORIENT_90;
        end else begin
            o_cls.prop = r_yneg ? ORIENT_0 : ORIENT_180;
        end
    end

endmodule

FILE: hdl/tod_queue.sv
// Short queue of classified samples between front and back end.
// Depends on tod_pkg.
module tod_queue #(
    parameter int unsigned DEPTH = tod_pkg::TOD_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tod_pkg::t_cls  i_data,
    input  logic           i_pop,
    output tod_pkg::t_cls  o_data,
    output tod_pkg::t_q_sts o_sts
);
    import tod_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_sts.full  = (r_cnt == CW'(DEPTH));
    assign o_sts.empty = (r_cnt == '0);
    assign o_data      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: hdl/tod_back.sv
// Back end: debounce state and the registered result item.
// Depends on tod_pkg.
module tod_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_empty,
    input  tod_pkg::t_cls                        i_cls,
    input  tod_pkg::t_cfg                        i_cfg,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [tod_pkg::TOD_OUT_DATA_W-1:0]   o_data,
    output tod_pkg::t_back_sts                   o_sts
);
    import tod_pkg::*;

    t_orient     r_committed, n_committed;
    t_orient     r_pending,   n_pending;
    logic [31:0] r_since,     n_since;
    logic        r_out_vld;
    logic        r_changed;
    logic        commit;
    logic [31:0] elapsed;

    assign o_pop   = !i_empty && (!r_out_vld || i_ready);
    assign elapsed = i_cls.now_ms - r_since;

    always_comb begin
        n_committed = r_committed;
        n_pending   = r_pending;
        n_since     = r_since;
        commit      = 1'b0;
        if (!i_cls.has_prop || i_cls.prop == r_committed) begin
            n_pending = r_committed;
            n_since   = i_cls.now_ms;
        end else if (i_cls.prop != r_pending) begin
            n_pending = i_cls.prop;
            n_since   = i_cls.now_ms;
        end else if (elapsed >= 32'(i_cfg.debounce_ms)) begin
            n_committed = i_cls.prop;
            n_pending   = i_cls.prop;
            n_since     = i_cls.now_ms;
            commit      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_committed <= ORIENT_0;
            r_pending   <= ORIENT_0;
            r_since     <= '0;
            r_out_vld   <= 1'b0;
            r_changed   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_committed <= n_committed;
                r_pending   <= n_pending;
                r_since     <= n_since;
                r_changed   <= commit;
                r_out_vld   <= 1'b1;
            end else if (i_ready) begin
                r_out_vld   <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = {(TOD_OUT_DATA_W - 3)'(0), r_changed, r_committed};

    assign o_sts.pop       = o_pop;
    assign o_sts.commit    = o_pop && commit;
    assign o_sts.committed = r_committed;

endmodule

FILE: hdl/tilt_orientation_debouncer.sv
// Top level of the tilt orientation debouncer: config registers, front end,
// queue and back end. Depends on tod_pkg, tod_front, tod_queue, tod_back and the macros header.
//
//  channel   dir  handshake                      payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata x,y,z,now_ms; tuser sample_valid
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata orientation, changed
//  cfg       in   i_cfg_we                        i_cfg_idx, i_cfg_wdata
//
// One item per cycle while the output side is ready; a result passes through the
// squaring register, a queue entry and then the output register. Synchronous
// reset restores register defaults and 0 degrees.
// A stalled output fills the queue, after which the front end holds its item.
`include "tilt_orientation_debouncer_macros.svh"

module tilt_orientation_debouncer #(
    parameter int unsigned QUEUE_DEPTH = tod_pkg::TOD_QUEUE_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [79:48] now_ms
    input  logic [tod_pkg::TOD_IN_DATA_W-1:0]     i_s_axis_tdata,
    // [0] sample_valid
    input  logic [0:0]                            i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [1:0] orientation, [2] changed, rest zero
    output logic [tod_pkg::TOD_OUT_DATA_W-1:0]    o_m_axis_tdata,
    input  logic                                  i_cfg_we,
    input  logic [tod_pkg::TOD_CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tod_pkg::TOD_CFG_DATA_W-1:0]    i_cfg_wdata
);
    import tod_pkg::*;

    t_cfg      r_cfg;
    t_cls      fr_cls, q_cls;
    t_q_sts    q_sts;
    t_back_sts bk_sts;
    logic      fr_push;
    logic      bk_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= TOD_RST_DEBOUNCE;
            r_cfg.min_total_sq  <= TOD_RST_MIN_TOTAL;
            r_cfg.max_total_sq  <= TOD_RST_MAX_TOTAL;
            r_cfg.min_planar_sq <= TOD_RST_MIN_PLANAR;
            r_cfg.axis_margin   <= TOD_RST_MARGIN;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DEBOUNCE:    r_cfg.debounce_ms   <= i_cfg_wdata[15:0];
                REG_MIN_TOTAL:   r_cfg.min_total_sq  <= i_cfg_wdata;
                REG_MAX_TOTAL:   r_cfg.max_total_sq  <= i_cfg_wdata;
                REG_MIN_PLANAR:  r_cfg.min_planar_sq <= i_cfg_wdata;
                REG_AXIS_MARGIN: r_cfg.axis_margin   <= i_cfg_wdata[14:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    tod_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_data         (i_s_axis_tdata),
        .i_sample_valid (i_s_axis_tuser[0]),
        .i_cfg          (r_cfg),
        .i_full         (q_sts.full),
        .o_push         (fr_push),
        .o_cls          (fr_cls)
    );

    tod_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_data  (fr_cls),
        .i_pop   (bk_pop),
        .o_data  (q_cls),
        .o_sts   (q_sts)
    );

    tod_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_sts.empty),
        .i_cls   (q_cls),
        .i_cfg   (r_cfg),
        .o_pop   (bk_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_sts   (bk_sts)
    );

    `TOD_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, fr_push, !q_sts.full)
    `TOD_ASSERT_NEXT(a_commit_flags_item, i_clk, i_rst_n, bk_sts.commit,
                     o_m_axis_tvalid && o_m_axis_tdata[2])
    `TOD_ASSERT_NOW(a_commit_only_change, i_clk, i_rst_n,
                    $past(i_rst_n) && !$stable(bk_sts.committed), $past(bk_sts.commit))

endmodule

FILE: tb/tilt_orientation_debouncer_test.sv
`timescale 1ns / 1ps
// Self-checking bench for tilt_orientation_debouncer: streams accelerometer samples,
// predicts the committed orientation and commit flag, and checks every output item.
// Depends on tod_pkg and the tilt_orientation_debouncer RTL.
module tilt_orientation_debouncer_test;
    import tod_pkg::*;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               ok;
        logic [31:0]        now;
    } t_tilt_sample;

    typedef struct {
        t_orient orient;
        logic    changed;
    } t_orient_result;

    localparam int STALL_LIMIT = 2000;
    // no register lives here; writes to it must be dropped
    localparam logic [TOD_CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_valid = 1'b0;
    logic [TOD_IN_DATA_W-1:0]  s_data = '0;
    logic [0:0]                s_user = '0;
    logic                      m_ready = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [TOD_CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [TOD_CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                      s_ready;
    logic                      m_valid;
    logic [TOD_OUT_DATA_W-1:0] m_data;

    tilt_orientation_debouncer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    t_tilt_sample   sample_queue[$];
    t_orient_result orient_expect[$];

    t_cfg        model_cfg;
    t_orient     model_committed;
    t_orient     model_pending;
    logic [31:0] model_since;

    int          src_idle_pct = 10;
    int          snk_idle_pct = 10;
    logic        in_taken = 1'b0;
    int          mismatches = 0;
    int          stall_cycles = 0;
    logic [31:0] tb_now;

    // orientation tracker: classify the sample, then run the debounce
    function automatic t_orient_result track_orientation(t_tilt_sample s);
        longint         sx, sy, sz, planar, total, ax, ay, margin;
        logic           has_prop;
        logic           changed;
        t_orient        prop;
        logic [31:0]    gap;
        t_orient_result r;
        sx = s.x;
        sy = s.y;
        sz = s.z;
        planar = sx * sx + sy * sy;
        total = planar + sz * sz;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        margin = longint'(model_cfg.axis_margin);
        has_prop = 1'b0;
        changed = 1'b0;
        prop = model_committed;
        if (s.ok && total >= longint'(model_cfg.min_total_sq)
                 && total <= longint'(model_cfg.max_total_sq)
                 && planar >= longint'(model_cfg.min_planar_sq)) begin
            has_prop = 1'b1;
            if (ax > ay + margin)
                prop = (sx >= 0) ? ORIENT_90 : ORIENT_270;
            else if (ay > ax + margin)
                prop = (sy >= 0) ? ORIENT_180 : ORIENT_0;
        end
        gap = s.now - model_since;
        if (!has_prop || prop == model_committed) begin
            model_pending = model_committed;
            model_since = s.now;
        end else if (prop != model_pending) begin
            model_pending = prop;
            model_since = s.now;
        end else if (gap >= {16'h0, model_cfg.debounce_ms}) begin
            model_committed = prop;
            model_pending = prop;
            model_since = s.now;
            changed = 1'b1;
        end
        r.orient = model_committed;
        r.changed = changed;
        return r;
    endfunction

    // sender: a new item only once the current one has gone
    always @(negedge i_clk) begin
        t_tilt_sample nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (sample_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                nxt = sample_queue.pop_front();
                s_valid <= 1'b1;
                s_data <= {nxt.now, nxt.z, nxt.y, nxt.x};
                s_user <= nxt.ok;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // accepted items feed the tracker; output items are checked in order
    always @(posedge i_clk) begin
        t_tilt_sample   smp;
        t_orient_result want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                smp.x = s_data[15:0];
                smp.y = s_data[31:16];
                smp.z = s_data[47:32];
                smp.now = s_data[79:48];
                smp.ok = s_user[0];
                orient_expect.push_back(track_orientation(smp));
            end
            if (m_valid && m_ready) begin
                if (orient_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output item %h", m_data);
                end else begin
                    want = orient_expect.pop_front();
                    if (m_data[1:0] !== want.orient || m_data[2] !== want.changed
                            || m_data[TOD_OUT_DATA_W-1:3] !== '0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: orientation exp %0d got %0d, ",
                                      "changed exp %0b got %0b, pad %h"},
                                     want.orient, m_data[1:0], want.changed, m_data[2],
                                     m_data[TOD_OUT_DATA_W-1:3]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_tilt_sample hold_sample(t_orient o);
        int           major, minor, tilt;
        t_tilt_sample s;
        major = $urandom_range(2500, 6000);
        minor = int'($urandom_range(0, 3000)) - 1500;
        tilt = int'($urandom_range(0, 5000)) - 2500;
        case (o)
            ORIENT_90: begin
                s.x = 16'(major);
                s.y = 16'(minor);
            end
            ORIENT_270: begin
                s.x = 16'(-major);
                s.y = 16'(minor);
            end
            ORIENT_180: begin
                s.x = 16'(minor);
                s.y = 16'(major);
            end
            default: begin
                s.x = 16'(minor);
                s.y = 16'(-major);
            end
        endcase
        s.z = 16'(tilt);
        s.ok = 1'b1;
        s.now = tb_now;
        return s;
    endfunction

    function automatic void queue_sample(int x, int y, int z, logic ok, logic [31:0] now);
        t_tilt_sample s;
        s.x = 16'(x);
        s.y = 16'(y);
        s.z = 16'(z);
        s.ok = ok;
        s.now = now;
        sample_queue.push_back(s);
    endfunction

    // mostly held orientations with rising timestamps, the rest noise
    task automatic run_random(int count);
        int           made, len, kind, m;
        t_tilt_sample s;
        t_orient      o;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 99) < 75) begin
                o = t_orient'($urandom_range(0, 3));
                len = $urandom_range(2, 7);
                repeat (len) begin
                    tb_now += $urandom_range(0, model_cfg.debounce_ms / 2 + 60);
                    sample_queue.push_back(hold_sample(o));
                    made++;
                end
            end else begin
                kind = $urandom_range(0, 3);
                s = hold_sample(t_orient'($urandom_range(0, 3)));
                case (kind)
                    0: begin
                        s.x = 16'($urandom);
                        s.y = 16'($urandom);
                        s.z = 16'($urandom);
                        s.ok = 1'($urandom);
                        s.now = $urandom;
                    end
                    1: begin
                        // |x| and |y| close, around the margin
                        m = (model_cfg.axis_margin > 1000) ? 1000 : int'(model_cfg.axis_margin);
                        len = $urandom_range(2000, 6000);
                        s.x = $urandom_range(0, 1) ? 16'(len) : 16'(-len);
                        len = len + int'($urandom_range(0, 2 * m)) - m;
                        s.y = $urandom_range(0, 1) ? 16'(len) : 16'(-len);
                    end
                    2: s.ok = 1'b0;
                    default: begin
                        tb_now = $urandom;
                        s.now = tb_now;
                    end
                endcase
                sample_queue.push_back(s);
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (sample_queue.size() != 0 || s_valid || orient_expect.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [TOD_CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_DEBOUNCE:    model_cfg.debounce_ms = val[15:0];
            REG_MIN_TOTAL:   model_cfg.min_total_sq = val;
            REG_MAX_TOTAL:   model_cfg.max_total_sq = val;
            REG_MIN_PLANAR:  model_cfg.min_planar_sq = val;
            REG_AXIS_MARGIN: model_cfg.axis_margin = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] deb, logic [31:0] min_t, logic [31:0] max_t,
                              logic [31:0] min_p, logic [31:0] margin);
        wait_idle();
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_MIN_TOTAL, min_t);
        write_reg(REG_MAX_TOTAL, max_t);
        write_reg(REG_MIN_PLANAR, min_p);
        write_reg(REG_AXIS_MARGIN, margin);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        model_cfg = '{debounce_ms: TOD_RST_DEBOUNCE, min_total_sq: TOD_RST_MIN_TOTAL,
                      max_total_sq: TOD_RST_MAX_TOTAL, min_planar_sq: TOD_RST_MIN_PLANAR,
                      axis_margin: TOD_RST_MARGIN};
        model_committed = ORIENT_0;
        model_pending = ORIENT_0;
        model_since = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings
        queue_sample(0, 4096, 0, 1'b1, 1000);
        queue_sample(0, 4096, 0, 1'b1, 1249);
        queue_sample(0, 4096, 0, 1'b1, 1250);
        queue_sample(0, 4096, 0, 1'b0, 1300);
        queue_sample(4096, 0, 0, 1'b1, 1300);
        queue_sample(-4096, 0, 0, 1'b1, 1600);
        queue_sample(-4096, 0, 0, 1'b1, 1850);
        queue_sample(3000, 3000, 0, 1'b1, 1900);
        queue_sample(4000, 3508, 0, 1'b1, 1950);     // lead equals margin
        queue_sample(2000, 0, 0, 1'b1, 2000);        // total too small
        queue_sample(2048, 0, 0, 1'b1, 2010);        // total exactly at minimum
        queue_sample(2048, 0, 0, 1'b1, 2260);        // gap exactly at debounce
        queue_sample(32767, 32767, 32767, 1'b1, 2300);
        queue_sample(-32768, -32768, -32768, 1'b0, 2310);
        queue_sample(0, 1000, 4096, 1'b1, 2320);     // planar too small
        queue_sample(0, 0, 0, 1'b1, 2330);
        queue_sample(0, -4096, 0, 1'b1, 32'hFFFF_FFA0);
        queue_sample(0, -4096, 0, 1'b1, 32'h0000_0060);
        queue_sample(0, -4096, 0, 1'b1, 32'h0000_00A0); // commit across wrap
        queue_sample(0, 4096, 0, 1'b1, 32'h0000_00B0);
        queue_sample(4096, 0, 0, 1'b1, 32'h0000_01B0);
        queue_sample(0, 4096, 0, 1'b1, 32'h0000_0300);
        tb_now = 32'h0000_1000;

        // widest window, no margin, no debounce; plus a dropped write
        wait_idle();
        write_reg(REG_UNUSED, $urandom);
        set_config(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        run_random(200);

        // longest debounce and largest margin
        set_config(32'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'h7FFF);
        queue_sample(-32768, 0, 0, 1'b1, tb_now);
        tb_now += 32'hFFFF;
        queue_sample(-32768, 0, 0, 1'b1, tb_now);
        run_random(150);

        // minimum above maximum: everything rejected
        set_config(32'd100, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd492);
        run_random(100);

        // reset values again, both sides flat out, sender drains halfway
        set_config(TOD_RST_DEBOUNCE, TOD_RST_MIN_TOTAL, TOD_RST_MAX_TOTAL,
                   TOD_RST_MIN_PLANAR, TOD_RST_MARGIN);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(150);
        wait_idle();
        run_random(150);
        wait_idle();
        src_idle_pct = 10;
        snk_idle_pct = 10;

        repeat (3) begin
            set_config($urandom_range(0, 600), $urandom_range(0, 8000000),
                       $urandom_range(30000000, 200000000), $urandom_range(0, 4000000),
                       $urandom_range(0, 1500));
            run_random(220);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && orient_expect.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
